@@ hw/rtl/cfxa_pkg.sv @@
package cfxa_pkg;

    // action codes
    localparam logic [3:0] ACT_ADD     = 4'd0;
    localparam logic [3:0] ACT_SUB     = 4'd1;
    localparam logic [3:0] ACT_MUL     = 4'd2;
    localparam logic [3:0] ACT_DIV     = 4'd3;
    localparam logic [3:0] ACT_MULDIV  = 4'd4;
    localparam logic [3:0] ACT_NEG     = 4'd5;
    localparam logic [3:0] ACT_ABS     = 4'd6;
    localparam logic [3:0] ACT_FLOOR   = 4'd7;
    localparam logic [3:0] ACT_CEIL    = 4'd8;
    localparam logic [3:0] ACT_ROUND   = 4'd9;
    localparam logic [3:0] ACT_FROMINT = 4'd10;
    localparam logic [3:0] ACT_CLAMP   = 4'd11;
    localparam logic [3:0] ACT_MIN     = 4'd12;
    localparam logic [3:0] ACT_MAX     = 4'd13;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // how the final stage treats the divider output
    localparam logic [2:0] K_SIMPLE  = 3'd0;
    localparam logic [2:0] K_MD      = 3'd1;
    localparam logic [2:0] K_FLOOR   = 3'd2;
    localparam logic [2:0] K_CEIL    = 3'd3;
    localparam logic [2:0] K_ROUND   = 3'd4;
    localparam logic [2:0] K_FROMINT = 3'd5;

    localparam int unsigned DIV_STAGES = 128;
    localparam logic [31:0] SCALE_RST  = 32'd65536;

    typedef struct packed {
        logic        [3:0]  action;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
        logic signed [63:0] operand_c;
    } t_in_req;

    typedef struct packed {
        logic signed [63:0] result;
        logic        [1:0]  status;
    } t_out_req;

    // control that rides along with the divider data
    typedef struct packed {
        logic        neg;
        logic [2:0]  kind;
        logic        dz;
        logic [63:0] sres;
        logic [1:0]  sst;
    } t_side;

endpackage

@@ hw/rtl/cfxa_div_pipe.sv @@
module cfxa_div_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [127:0]          i_w,
    input  logic [63:0]           i_mz,
    input  cfxa_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic [127:0]          o_q,
    output logic [63:0]           o_rem,
    output logic [63:0]           o_mz,
    output cfxa_pkg::t_side       o_side
);
    import cfxa_pkg::*;

    // stage inputs
    logic         c_v    [0:DIV_STAGES-1];
    logic [127:0] c_w    [0:DIV_STAGES-1];
    logic [63:0]  c_rem  [0:DIV_STAGES-1];
    logic [63:0]  c_mz   [0:DIV_STAGES-1];
    t_side        c_side [0:DIV_STAGES-1];
    // stage registers
    logic         r_v    [0:DIV_STAGES-1];
    logic [127:0] r_w    [0:DIV_STAGES-1];
    logic [63:0]  r_rem  [0:DIV_STAGES-1];
    logic [63:0]  r_mz   [0:DIV_STAGES-1];
    t_side        r_side [0:DIV_STAGES-1];
    logic [127:0] n_w    [0:DIV_STAGES-1];
    logic [63:0]  n_rem  [0:DIV_STAGES-1];

    // one quotient bit per stage: the dividend shifts out the top while
    // quotient bits shift in at the bottom
    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stg
            logic [64:0] t;
            logic        ge;
            if (k == 0) begin : g_first
                assign c_v[k]    = i_valid;
                assign c_w[k]    = i_w;
                assign c_rem[k]  = 64'd0;
                assign c_mz[k]   = i_mz;
                assign c_side[k] = i_side;
            end else begin : g_next
                assign c_v[k]    = r_v[k-1];
                assign c_w[k]    = r_w[k-1];
                assign c_rem[k]  = r_rem[k-1];
                assign c_mz[k]   = r_mz[k-1];
                assign c_side[k] = r_side[k-1];
            end

            assign t        = {c_rem[k], c_w[k][127]};
            assign ge       = t >= {1'b0, c_mz[k]};
            assign n_rem[k] = ge ? 64'(t - {1'b0, c_mz[k]}) : t[63:0];
            assign n_w[k]   = {c_w[k][126:0], ge};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= c_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_w[k]    <= n_w[k];
                    r_rem[k]  <= n_rem[k];
                    r_mz[k]   <= c_mz[k];
                    r_side[k] <= c_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_q     = r_w[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1];
    assign o_mz    = r_mz[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

@@ hw/rtl/checked_fixed_point_alu_top.sv @@
// Checked 64-bit signed fixed-point ALU.
// Input channel: i_in_valid / o_in_ready carry one request (action and three
// operands); output channel: o_out_valid / i_out_ready carry one response
// (result and status) per request, in request order.
// Configuration: i_cfg_we writes i_cfg_wdata into the scale register;
// write it only while no request is in flight.
// Throughput: one request per cycle while i_out_ready does not stall the
// pipeline. The request passes 134 register stages, the first loaded at
// the accepting edge: input, decode, two multiply stages, the 128-stage
// restoring divider (one quotient bit per stage), a rounding stage and
// the output register.
// Every operation takes the same path, so responses never reorder.
// Reset (synchronous, active low) clears all stage valid bits and sets
// scale to 65536.
// When the receiver holds i_out_ready low with a response waiting, the whole
// pipeline freezes and o_in_ready drops; nothing is lost or repeated.
module checked_fixed_point_alu_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cfxa_pkg::t_in_req     i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cfxa_pkg::t_out_req    o_out_req,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata
);
    import cfxa_pkg::*;

    logic        en;
    logic [31:0] r_scale;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // stage 0: input register
    logic    r_v0;
    t_in_req r_req;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req <= i_in_req;
        end
    end

    // stage 1: decode, simple ops, operand magnitudes
    logic signed [63:0] a, b, c, x, y, z, sum, dif;
    logic [63:0] sres, mx, my, mz;
    logic [1:0]  sst;
    logic [2:0]  kind;
    logic        a_min;

    assign a     = r_req.operand_a;
    assign b     = r_req.operand_b;
    assign c     = r_req.operand_c;
    assign sum   = a + b;
    assign dif   = a - b;
    assign a_min = a == {1'b1, 63'd0};

    always_comb begin
        sres = 64'd0;
        sst  = ST_OK;
        kind = K_SIMPLE;
        x    = a;
        y    = b;
        z    = 64'sd1;
        unique case (r_req.action) inside
            ACT_ADD: begin
                if (a[63] == b[63] && sum[63] != a[63]) sst = ST_OVF;
                else sres = sum;
            end
            ACT_SUB: begin
                if (a[63] != b[63] && dif[63] != a[63]) sst = ST_OVF;
                else sres = dif;
            end
            ACT_NEG: begin
                if (a_min) sst = ST_OVF;
                else sres = -a;
            end
            ACT_ABS: begin
                if (a_min) sst = ST_OVF;
                else sres = a[63] ? -a : a;
            end
            ACT_CLAMP: sres = (a < b) ? b : ((a > c) ? c : a);
            ACT_MIN:   sres = (a <= b) ? a : b;
            ACT_MAX:   sres = (a >= b) ? a : b;
            ACT_MUL: begin
                kind = K_MD;
                z    = {32'd0, r_scale};
            end
            ACT_DIV: begin
                kind = K_MD;
                y    = {32'd0, r_scale};
                z    = b;
            end
            ACT_MULDIV: begin
                kind = K_MD;
                z    = c;
            end
            ACT_FLOOR, ACT_CEIL, ACT_ROUND: begin
                kind = (r_req.action == ACT_FLOOR) ? K_FLOOR :
                       (r_req.action == ACT_CEIL)  ? K_CEIL : K_ROUND;
                y    = 64'sd1;
                z    = {32'd0, r_scale};
            end
            ACT_FROMINT: begin
                kind = K_FROMINT;
                y    = {32'd0, r_scale};
            end
            default: ;
        endcase
    end

    assign mx = x[63] ? 64'(-x) : 64'(x);
    assign my = y[63] ? 64'(-y) : 64'(y);
    assign mz = z[63] ? 64'(-z) : 64'(z);

    logic        r_v1;
    logic [63:0] r_mx, r_my, r_mz1;
    t_side       r_side1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx          <= mx;
            r_my          <= my;
            r_mz1         <= mz;
            r_side1.neg   <= x[63] ^ y[63] ^ z[63];
            r_side1.kind  <= kind;
            r_side1.dz    <= (z == 64'sd0);
            r_side1.sres  <= sres;
            r_side1.sst   <= sst;
        end
    end

    // stage 2: four 32x32 partial products
    logic        r_v2;
    logic [63:0] r_ll, r_hl, r_lh, r_hh, r_mz2;
    t_side       r_side2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ll    <= r_mx[31:0]  * r_my[31:0];
            r_hl    <= r_mx[63:32] * r_my[31:0];
            r_lh    <= r_mx[31:0]  * r_my[63:32];
            r_hh    <= r_mx[63:32] * r_my[63:32];
            r_mz2   <= r_mz1;
            r_side2 <= r_side1;
        end
    end

    // stage 3: combine into the 128-bit product
    logic        r_v3;
    logic [127:0] r_prod;
    logic [63:0]  r_mz3;
    t_side        r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= {64'd0, r_ll} + {32'd0, r_hl, 32'd0}
                     + {32'd0, r_lh, 32'd0} + {r_hh, 64'd0};
            r_mz3   <= r_mz2;
            r_side3 <= r_side2;
        end
    end

    // long division
    logic         d_v;
    logic [127:0] d_q;
    logic [63:0]  d_rem, d_mz;
    t_side        d_side;

    cfxa_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_w     (r_prod),
        .i_mz    (r_mz3),
        .i_side  (r_side3),
        .o_valid (d_v),
        .o_q     (d_q),
        .o_rem   (d_rem),
        .o_mz    (d_mz),
        .o_side  (d_side)
    );

    // rounding stage
    logic inc, rnz;
    assign rnz = d_rem != 64'd0;
    always_comb begin
        unique case (d_side.kind) inside
            K_MD, K_ROUND: inc = rnz && (d_rem >= 64'(d_mz - d_rem));
            K_FLOOR:       inc = rnz && d_side.neg;
            K_CEIL:        inc = rnz && !d_side.neg;
            default:       inc = 1'b0;
        endcase
    end

    logic         r_vf;
    logic [127:0] r_qf;
    t_side        r_sidef;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= d_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qf    <= d_q + {127'd0, inc};
            r_sidef <= d_side;
        end
    end

    // output stage: sign, range check, error zeroing
    logic        ovf;
    logic [63:0] sval;
    t_out_req    n_out;
    assign ovf  = (r_qf[127:64] != 64'd0) ||
                  (r_sidef.neg ? (r_qf[63:0] > {1'b1, 63'd0}) : r_qf[63]);
    assign sval = r_sidef.neg ? 64'(-r_qf[63:0]) : r_qf[63:0];

    always_comb begin
        n_out.result = 64'sd0;
        n_out.status = ST_OK;
        if (r_sidef.kind == K_SIMPLE) begin
            n_out.status = r_sidef.sst;
            if (r_sidef.sst == ST_OK) n_out.result = r_sidef.sres;
        end else if (r_sidef.kind == K_FROMINT) begin
            if (ovf) n_out.result = r_sidef.neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else n_out.result = sval;
        end else if (r_sidef.dz) begin
            n_out.status = ST_DIV0;
        end else if (ovf) begin
            n_out.status = ST_OVF;
        end else begin
            n_out.result = sval;
        end
    end

    logic     r_vo;
    t_out_req r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vf;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_req   = r_out;

endmodule
